// File: sv/pss_pkg.sv
// Shared types and constants for the plucked-string synthesizer.
// Depends on nothing; imported by plucked_string_synth and its checker.
package pss_pkg;

    localparam int LINE_DEPTH  = 1024;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int SAMPLE_BITS = 16;
    localparam int NOISE_W     = 16;
    localparam int DELAY_W     = 10;
    localparam int DECAY_W     = 16;
    localparam int STEP_W      = 24;
    localparam int GAIN_W      = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(480);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(58982);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(17476);

    // 0.5 in signed Q1.24
    localparam logic signed [GAIN_W-1:0] GAIN_START = GAIN_W'(1 << 23);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_SAMPLES = 2'd0,
        CFG_DECAY_GAIN    = 2'd1,
        CFG_GAIN_STEP     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               pluck;
        logic [NOISE_W-1:0] noise_left;
        logic [NOISE_W-1:0] noise_right;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } out_word_t;

endpackage

// File: sv/plucked_string_synth.sv
// Stereo plucked-string delay loop: two delay-line memories with read-modify-write.
// Depends on pss_pkg for the word types and constants.
//
// Usage:
//   s_valid/s_ready/s_word carry one input word per sample: a pluck flag and two
//   noise words. m_valid/m_ready/m_word return one stereo output word per input.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write delay_samples, decay_gain and
//   gain_step (indexes 0..2, index 3 is ignored); cfg_ready is always high.
// Throughput: one word per cycle while not stalled. Each lane's memory does one
//   read (the tap delay_samples behind) and one write (new sample) per such cycle.
// Pipeline: memory read at the accepting edge, then the registered products, then
//   add/saturate into the output register behind m_valid. Words still in flight
//   are forwarded into the tap read, so any delay including 0 and 1 is exact.
// Reset: write pointer and burst gain go to zero, registers to their defaults.
//   The memories are not swept; a fill flag plus the write pointer mark which
//   entries were written, and unwritten taps read as zero. Input is taken
//   from the first cycle after reset.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; otherwise s_ready is high.
module plucked_string_synth (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pss_pkg::in_word_t              s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pss_pkg::out_word_t             m_word,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pss_pkg::*;

    localparam int EX_PROD_W = GAIN_W + NOISE_W;
    localparam int FB_PROD_W = DECAY_W + 1 + SAMPLE_BITS;
    localparam int SUM_W     = SAMPLE_BITS + 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // configuration
    logic [DELAY_W-1:0] delay_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [STEP_W-1:0]  step_reg;

    // loop state
    logic [ADDR_W-1:0]        wp_reg;
    logic                     full_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    // stage 1: tap read in flight
    logic                 s1_valid_reg;
    logic [ADDR_W-1:0]    s1_wp_reg;
    logic [ADDR_W-1:0]    s1_rd_reg;
    logic                 s1_written_reg;
    logic [STEP_W-1:0]    s1_gain_reg;
    logic [NOISE_W-1:0]   s1_noise_l_reg;
    logic [NOISE_W-1:0]   s1_noise_r_reg;
    sample_t              rd_l_reg;
    sample_t              rd_r_reg;

    // stage 2: products
    logic                        s2_valid_reg;
    logic [ADDR_W-1:0]           s2_wp_reg;
    logic                        s2_self_reg;
    sample_t                     s2_tap_l_reg;
    sample_t                     s2_tap_r_reg;
    logic signed [EX_PROD_W-1:0] s2_ex_l_reg;
    logic signed [EX_PROD_W-1:0] s2_ex_r_reg;
    logic signed [FB_PROD_W-1:0] s2_fb_l_reg;
    logic signed [FB_PROD_W-1:0] s2_fb_r_reg;

    // last memory write
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    sample_t           lw_l_reg;
    sample_t           lw_r_reg;

    logic      m_valid_reg;
    out_word_t m_word_reg;

    sample_t left_mem  [LINE_DEPTH];
    sample_t right_mem [LINE_DEPTH];

    logic                     adv;
    logic                     accept;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     rd_written;
    logic signed [GAIN_W-1:0] gain_eff;
    logic                     gain_pos;
    logic signed [GAIN_W-1:0] gain_next;
    sample_t                  tap_l;
    sample_t                  tap_r;
    logic signed [SUM_W-1:0]  sum_l;
    logic signed [SUM_W-1:0]  sum_r;
    sample_t                  y_l;
    sample_t                  y_r;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign accept    = s_valid && adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;

    assign rd_addr    = wp_reg - ADDR_W'(delay_reg);
    assign rd_written = full_reg || (rd_addr < wp_reg);

    assign gain_eff  = s_word.pluck ? GAIN_START : gain_reg;
    assign gain_pos  = !gain_eff[GAIN_W-1] && (|gain_eff);
    assign gain_next = gain_eff[GAIN_W-1] ? gain_eff
                                          : gain_eff - $signed({1'b0, step_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            decay_reg <= DECAY_RESET;
            step_reg  <= STEP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DELAY_SAMPLES: delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_DECAY_GAIN:    decay_reg <= cfg_data[DECAY_W-1:0];
                CFG_GAIN_STEP:     step_reg  <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
            gain_reg <= '0;
        end else if (accept) begin
            wp_reg   <= wp_reg + ADDR_W'(1);
            gain_reg <= gain_next;
            if (wp_reg == ADDR_W'(LINE_DEPTH - 1)) begin
                full_reg <= 1'b1;
            end
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_wp_reg      <= wp_reg;
            s1_rd_reg      <= rd_addr;
            s1_written_reg <= rd_written;
            s1_gain_reg    <= gain_pos ? gain_eff[STEP_W-1:0] : '0;
            s1_noise_l_reg <= s_word.noise_left;
            s1_noise_r_reg <= s_word.noise_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_l_reg <= left_mem[rd_addr];
            if (s2_valid_reg) begin
                left_mem[s2_wp_reg] <= y_l;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_r_reg <= right_mem[rd_addr];
            if (s2_valid_reg) begin
                right_mem[s2_wp_reg] <= y_r;
            end
        end
    end

    // tap value: pending write first, then the latest write, then memory or zero
    always_comb begin
        priority if (s2_valid_reg && (s2_wp_reg == s1_rd_reg)) begin
            tap_l = y_l;
            tap_r = y_r;
        end else if (lw_valid_reg && (lw_addr_reg == s1_rd_reg)) begin
            tap_l = lw_l_reg;
            tap_r = lw_r_reg;
        end else if (s1_written_reg) begin
            tap_l = rd_l_reg;
            tap_r = rd_r_reg;
        end else begin
            tap_l = '0;
            tap_r = '0;
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_wp_reg    <= s1_wp_reg;
            s2_self_reg  <= (s1_rd_reg == s1_wp_reg);
            s2_tap_l_reg <= tap_l;
            s2_tap_r_reg <= tap_r;
            // noise - 32768 is the noise word with its top bit inverted
            s2_ex_l_reg  <= $signed({1'b0, s1_gain_reg})
                          * $signed({~s1_noise_l_reg[NOISE_W-1], s1_noise_l_reg[NOISE_W-2:0]});
            s2_ex_r_reg  <= $signed({1'b0, s1_gain_reg})
                          * $signed({~s1_noise_r_reg[NOISE_W-1], s1_noise_r_reg[NOISE_W-2:0]});
            s2_fb_l_reg  <= $signed({1'b0, decay_reg}) * tap_l;
            s2_fb_r_reg  <= $signed({1'b0, decay_reg}) * tap_r;
        end
    end

    assign sum_l = SUM_W'(s2_ex_l_reg >>> 24) + SUM_W'(s2_fb_l_reg >>> DECAY_W);
    assign sum_r = SUM_W'(s2_ex_r_reg >>> 24) + SUM_W'(s2_fb_r_reg >>> DECAY_W);
    assign y_l   = sat_sample(sum_l);
    assign y_r   = sat_sample(sum_r);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s2_valid_reg;
            if (s2_valid_reg) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg) begin
            lw_addr_reg          <= s2_wp_reg;
            lw_l_reg             <= y_l;
            lw_r_reg             <= y_r;
            m_word_reg.out_left  <= s2_self_reg ? y_l : s2_tap_l_reg;
            m_word_reg.out_right <= s2_self_reg ? y_r : s2_tap_r_reg;
        end
    end

endmodule

// File: sv/pss_checker.sv
// Port-level checker for plucked_string_synth, bound to every instance.
// Depends on pss_pkg for the word types.
module pss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input pss_pkg::in_word_t              s_word,
    input logic                           m_valid,
    input logic                           m_ready,
    input pss_pkg::out_word_t             m_word,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [pss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pss_pkg::*;

    logic cfg_seen;
    logic in_pluck;

    assign cfg_seen = cfg_valid && (cfg_index != '0 || cfg_data != '0);
    assign in_pluck = s_word.pluck;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid not cleared by reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("output word changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output register");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_seen || in_pluck || s_valid) |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (.*);
